[hdl/ffa_pkg.sv]
`timescale 1ns / 1ps

package ffa_pkg;

  localparam int HEAP_UNITS = 65536;
  localparam int UNIT_BYTES = 16;

  localparam int REQ_W   = 21;
  localparam int ADDR_W  = 20;
  localparam int UNIT_W  = $clog2(HEAP_UNITS);
  localparam int LINK_W  = UNIT_W + 1;
  localparam int OFS_W   = $clog2(UNIT_BYTES);
  localparam int UNITS_W = REQ_W - OFS_W + 1;
  localparam int NEED_W  = UNITS_W + 1;
  localparam int AU_W    = ADDR_W - OFS_W;

  // list terminator, one past the last unit
  localparam logic [LINK_W-1:0] NIL_LINK = LINK_W'(HEAP_UNITS);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_BAD_FREE = 2'd2
  } status_t;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_t;

  typedef struct packed {
    logic    clr_step;
    logic    start;
    logic    walk_rd;
    logic    advance;
    logic    split_a;
    logic    split_b;
    logic    mark_rd;
    logic    free_commit;
    logic    res_set;
    status_t res_code;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic walk_stop;
    logic fit;
    logic rem_ok;
    logic addr_null;
    logic addr_bad;
    logic mark_set;
  } dp_sts_t;

endpackage

[hdl/first_fit_free_list_allocator.sv]
// first-fit free-list heap allocator, one request at a time
// allocate: a table read and a fit check per free-list block visited, then the split states
//   S_SPLIT_A and S_SPLIT_B, then S_RESULT loads the output register
// free: mark read and check; next request is taken while a result still waits for out_ready
// after reset a clearing pass sweeps all 65536 allocated marks, one per cycle,
//   and writes the whole-heap header at unit 0; no request is taken until it ends
`timescale 1ns / 1ps

module first_fit_free_list_allocator import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_action,
  input  logic [REQ_W-1:0]  in_req_bytes,
  input  logic [ADDR_W-1:0] in_block_addr,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_payload_addr
);

  // controller to datapath commands and datapath flags back
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: clearing pass, list walk, split, free check, result handoff
  ffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // heap tables (size, next link, allocated mark), walk registers, output register
  ffa_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_bytes     (in_req_bytes),
    .in_block_addr    (in_block_addr),
    .out_status       (out_status),
    .out_payload_addr (out_payload_addr)
  );

endmodule

[hdl/ffa_dp.sv]
`timescale 1ns / 1ps

module ffa_dp import ffa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_sts_t           sts,
  input  logic [REQ_W-1:0]  in_req_bytes,
  input  logic [ADDR_W-1:0] in_block_addr,
  output logic [1:0]        out_status,
  output logic [ADDR_W-1:0] out_payload_addr
);

  // heap tables
  logic [LINK_W-1:0] size_mem [HEAP_UNITS];
  logic [LINK_W-1:0] next_mem [HEAP_UNITS];
  logic              mark_mem [HEAP_UNITS];

  logic [LINK_W-1:0]  head_r, head_nxt;
  logic [UNIT_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [LINK_W-1:0]  cur_r, prev_r, cnt_r;
  logic [UNITS_W-1:0] units_r;
  logic [NEED_W-1:0]  need_r;
  logic [ADDR_W-1:0]  addr_r;
  logic [LINK_W-1:0]  rd_size_r, rd_next_r;
  logic               rd_mark_r;
  logic [1:0]         res_status_r, out_status_r;
  logic [ADDR_W-1:0]  res_addr_r, out_addr_r;

  logic [UNITS_W-1:0]       units_calc;
  logic [NEED_W-1:0]        rem_sum;
  logic [UNIT_W-1:0]        cur_idx, rem_idx, hdr_idx;
  logic [AU_W-1:0]          addr_units;
  logic [UNIT_W+OFS_W:0]    pay_full;

  logic              size_we, next_we, mark_we, mark_wd;
  logic [UNIT_W-1:0] size_wa, next_wa, mark_wa;
  logic [LINK_W-1:0] size_wd, next_wd;

  // request rounded up to whole units, zero bytes counts as one unit
  always_comb begin
    if (in_req_bytes == '0) begin
      units_calc = UNITS_W'(1);
    end else begin
      units_calc = {1'b0, in_req_bytes[REQ_W-1:OFS_W]}
                 + UNITS_W'(|in_req_bytes[OFS_W-1:0]);
    end
  end

  assign cur_idx    = cur_r[UNIT_W-1:0];
  assign rem_sum    = NEED_W'(cur_r) + need_r;
  assign rem_idx    = rem_sum[UNIT_W-1:0];
  assign addr_units = addr_r[ADDR_W-1:OFS_W];
  assign hdr_idx    = UNIT_W'(addr_units - AU_W'(1));
  assign pay_full   = {({1'b0, cur_idx} + (UNIT_W+1)'(1)), OFS_W'(0)};

  assign sts.clr_done  = (clr_idx_r == '1);
  assign sts.walk_stop = (cur_r >= NIL_LINK) || (cnt_r == NIL_LINK);
  assign sts.fit       = (NEED_W'(rd_size_r) >= need_r);
  assign sts.rem_ok    = (rem_sum < NEED_W'(HEAP_UNITS));
  assign sts.addr_null = (addr_r == '0);
  assign sts.addr_bad  = (addr_r[OFS_W-1:0] != '0) || (addr_units == '0)
                      || ({1'b0, addr_units} > (AU_W+1)'(HEAP_UNITS));
  assign sts.mark_set  = rd_mark_r;

  // write port selection
  always_comb begin
    size_we = 1'b0;
    size_wa = '0;
    size_wd = '0;
    next_we = 1'b0;
    next_wa = '0;
    next_wd = '0;
    mark_we = 1'b0;
    mark_wa = '0;
    mark_wd = 1'b0;
    if (cmd.clr_step) begin
      mark_we = 1'b1;
      mark_wa = clr_idx_r;
      if (clr_idx_r == '0) begin
        size_we = 1'b1;
        size_wd = LINK_W'(HEAP_UNITS - 1);
        next_we = 1'b1;
        next_wd = NIL_LINK;
      end
    end else if (cmd.split_a) begin
      size_we = 1'b1;
      size_wa = rem_idx;
      size_wd = LINK_W'(NEED_W'(rd_size_r) - need_r);
      next_we = 1'b1;
      next_wa = rem_idx;
      next_wd = rd_next_r;
      mark_we = 1'b1;
      mark_wa = cur_idx;
      mark_wd = 1'b1;
    end else if (cmd.split_b) begin
      size_we = 1'b1;
      size_wa = cur_idx;
      size_wd = LINK_W'(units_r);
      if (prev_r != NIL_LINK) begin
        next_we = 1'b1;
        next_wa = prev_r[UNIT_W-1:0];
        next_wd = LINK_W'(rem_idx);
      end
    end else if (cmd.free_commit) begin
      next_we = 1'b1;
      next_wa = hdr_idx;
      next_wd = head_r;
      mark_we = 1'b1;
      mark_wa = hdr_idx;
      mark_wd = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (size_we) begin
      size_mem[size_wa] <= size_wd;
    end
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    if (cmd.walk_rd) begin
      rd_size_r <= size_mem[cur_idx];
      rd_next_r <= next_mem[cur_idx];
    end
    if (cmd.mark_rd) begin
      rd_mark_r <= mark_mem[hdr_idx];
    end
  end

  always_comb begin
    head_nxt = head_r;
    if (cmd.split_b && (prev_r == NIL_LINK)) begin
      head_nxt = LINK_W'(rem_idx);
    end else if (cmd.free_commit) begin
      head_nxt = LINK_W'(hdr_idx);
    end
  end

  assign clr_idx_nxt = cmd.clr_step ? clr_idx_r + UNIT_W'(1) : clr_idx_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      clr_idx_r <= '0;
    end else begin
      head_r    <= head_nxt;
      clr_idx_r <= clr_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      units_r <= units_calc;
      need_r  <= {1'b0, units_calc} + NEED_W'(1);
      addr_r  <= in_block_addr;
      cur_r   <= head_r;
      prev_r  <= NIL_LINK;
      cnt_r   <= '0;
    end else begin
      if (cmd.walk_rd) begin
        cnt_r <= cnt_r + LINK_W'(1);
      end
      if (cmd.advance) begin
        prev_r <= cur_r;
        cur_r  <= rd_next_r;
      end
    end
    if (cmd.split_b) begin
      res_status_r <= ST_OK;
      res_addr_r   <= pay_full[ADDR_W-1:0];
    end else if (cmd.res_set) begin
      res_status_r <= cmd.res_code;
      res_addr_r   <= '0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_addr_r   <= res_addr_r;
    end
  end

  assign out_status       = out_status_r;
  assign out_payload_addr = out_addr_r;

endmodule

[hdl/ffa_ctrl.sv]
`timescale 1ns / 1ps

module ffa_ctrl import ffa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  logic    in_action,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [8:0] {
    S_CLEAR    = 9'b000000001,
    S_IDLE     = 9'b000000010,
    S_WALK_RD  = 9'b000000100,
    S_WALK_CHK = 9'b000001000,
    S_SPLIT_A  = 9'b000010000,
    S_SPLIT_B  = 9'b000100000,
    S_FREE_RD  = 9'b001000000,
    S_FREE_CHK = 9'b010000000,
    S_RESULT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.res_code = ST_OK;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = (in_action == ACT_FREE) ? S_FREE_RD : S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts.walk_stop) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OOM;
          state_nxt    = S_RESULT;
        end else begin
          cmd.walk_rd = 1'b1;
          state_nxt   = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (!sts.fit) begin
          cmd.advance = 1'b1;
          state_nxt   = S_WALK_RD;
        end else if (sts.rem_ok) begin
          state_nxt = S_SPLIT_A;
        end else begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OOM;
          state_nxt    = S_RESULT;
        end
      end
      S_SPLIT_A: begin
        cmd.split_a = 1'b1;
        state_nxt   = S_SPLIT_B;
      end
      S_SPLIT_B: begin
        cmd.split_b = 1'b1;
        state_nxt   = S_RESULT;
      end
      S_FREE_RD: begin
        if (sts.addr_null) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_OK;
          state_nxt    = S_RESULT;
        end else if (sts.addr_bad) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_BAD_FREE;
          state_nxt    = S_RESULT;
        end else begin
          cmd.mark_rd = 1'b1;
          state_nxt   = S_FREE_CHK;
        end
      end
      S_FREE_CHK: begin
        cmd.res_set = 1'b1;
        if (sts.mark_set) begin
          cmd.free_commit = 1'b1;
          cmd.res_code    = ST_OK;
        end else begin
          cmd.res_code = ST_BAD_FREE;
        end
        state_nxt = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
